@@ hdl/mrdr_pkg.sv @@
// Shared widths, register codes and pipeline stage type for the digit reversal unit
`default_nettype none
package mrdr_pkg;
   localparam int POS_W           = 16;
   localparam int RADIX_W         = 17;
   localparam int REM_W           = 17;
   localparam int PROD_W          = 17;
   localparam int CNT_W           = 3;
   localparam int NUM_RADIX       = 6;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 5;
   localparam int CELLS_PER_DIGIT = POS_W + 1;

   localparam logic [2:0] REG_DIGIT_COUNT = 3'd0;
   localparam logic [2:0] REG_RADIX_0     = 3'd1;
   localparam logic [2:0] REG_RADIX_1     = 3'd2;
   localparam logic [2:0] REG_RADIX_2     = 3'd3;
   localparam logic [2:0] REG_RADIX_3     = 3'd4;
   localparam logic [2:0] REG_RADIX_4     = 3'd5;
   localparam logic [2:0] REG_RADIX_5     = 3'd6;

   typedef struct packed {
      logic              valid;
      logic [POS_W-1:0]  x;     // dividend shifting out, quotient shifting in
      logic [REM_W-1:0]  rem;
      logic [POS_W-1:0]  acc;
      logic [PROD_W-1:0] prod;
      logic              big;
   } mrdr_stage_type;
endpackage
`default_nettype wire

@@ hdl/mrdr_if.sv @@
// Item channel interfaces for position requests and source index responses
`default_nettype none
interface mrdr_req_if;
   import mrdr_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   modport source (output valid, output position, input ready);
   modport sink (input valid, input position, output ready);
endinterface

interface mrdr_rsp_if;
   import mrdr_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] source_index;
   logic             out_of_range;
   modport source (output valid, output source_index, output out_of_range, input ready);
   modport sink (input valid, input source_index, input out_of_range, output ready);
endinterface
`default_nettype wire

@@ hdl/mrdr_div_cell.sv @@
// One restoring division step: produces one quotient bit per cell
`default_nettype none
module mrdr_div_cell
   import mrdr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [RADIX_W-1:0] radix,
   input  wire mrdr_stage_type     stage_in,
   output      mrdr_stage_type     stage_out
);
   mrdr_stage_type   stage_ff;
   mrdr_stage_type   next_in;
   logic [REM_W:0]   shifted;
   logic             ge;

   always_comb begin
      shifted = {stage_in.rem, stage_in.x[POS_W-1]};
      ge      = shifted >= {1'b0, radix};
      next_in = stage_in;
      next_in.rem = ge ? REM_W'(shifted - {1'b0, radix}) : shifted[REM_W-1:0];
      next_in.x   = {stage_in.x[POS_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

@@ hdl/mrdr_digit_cell.sv @@
// Digit close-out: folds the remainder into the reversed index and tracks the radix product
`default_nettype none
module mrdr_digit_cell
   import mrdr_pkg::*;
#(
   parameter int MAX_POINTS = 65536
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [RADIX_W-1:0] radix,
   input  wire mrdr_stage_type     stage_in,
   output      mrdr_stage_type     stage_out
);
   mrdr_stage_type          stage_ff;
   mrdr_stage_type          next_in;
   logic [POS_W+RADIX_W-1:0]  acc_mul;
   logic [PROD_W+RADIX_W-1:0] prod_mul;

   always_comb begin
      acc_mul  = stage_in.acc * radix;
      prod_mul = stage_in.prod * radix;
      next_in  = stage_in;
      next_in.acc = POS_W'(acc_mul) + stage_in.rem[POS_W-1:0];
      next_in.rem = '0;
      if (!stage_in.big) begin
         next_in.prod = prod_mul[PROD_W-1:0];
         next_in.big  = prod_mul > (PROD_W+RADIX_W)'(MAX_POINTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

@@ hdl/mixed_radix_digit_reversal_unit.sv @@
// Top level: register file and the chain of division and digit cells
//
// Usage: write digit_count and radix_0..radix_5 over the csr APB port (byte
// address 4*i), then stream positions on req_ch. Each item returns one
// source_index with out_of_range on rsp_ch, in order.
// Every digit runs through POS_W restoring division cells (one quotient bit
// each) and one digit cell, each of them a registered stage. Unused digits
// run with radix 1 and pass through unchanged.
// Throughput is one item per clock while rsp_ch does not stall; the chain moves one cell per cycle.
// A stall on rsp_ch freezes the whole chain and req_ch.ready drops; the last
// stage doubles as the output register.
// Reset clears all stage valid bits and loads digit_count=1, radix_0=2, the
// other radices 1. No clearing pass is needed.
`default_nettype none
module mixed_radix_digit_reversal_unit
   import mrdr_pkg::*;
#(
   parameter int MAX_DIGITS = 6,
   parameter int MAX_POINTS = 65536
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mrdr_req_if.sink                   req_ch,
   mrdr_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);
   localparam int NUM_CELLS = MAX_DIGITS * CELLS_PER_DIGIT;

   logic [CNT_W-1:0]   digit_count_ff;
   logic [RADIX_W-1:0] radix_ff [NUM_RADIX];
   logic [CNT_W-1:0]   cnt_eff;
   logic [2:0]         reg_idx;
   logic               csr_write;
   logic               advance;
   mrdr_stage_type     chain [NUM_CELLS+1];

   assign reg_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= CNT_W'(1);
         radix_ff[0]    <= RADIX_W'(2);
         for (int i = 1; i < NUM_RADIX; i++) begin
            radix_ff[i] <= RADIX_W'(1);
         end
      end else if (csr_write) begin
         case (reg_idx)
            REG_DIGIT_COUNT: digit_count_ff <= csr_pwdata[CNT_W-1:0];
            REG_RADIX_0:     radix_ff[0] <= csr_pwdata[RADIX_W-1:0];
            REG_RADIX_1:     radix_ff[1] <= csr_pwdata[RADIX_W-1:0];
            REG_RADIX_2:     radix_ff[2] <= csr_pwdata[RADIX_W-1:0];
            REG_RADIX_3:     radix_ff[3] <= csr_pwdata[RADIX_W-1:0];
            REG_RADIX_4:     radix_ff[4] <= csr_pwdata[RADIX_W-1:0];
            REG_RADIX_5:     radix_ff[5] <= csr_pwdata[RADIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DIGIT_COUNT: csr_prdata = CSR_DATA_W'(digit_count_ff);
         REG_RADIX_0:     csr_prdata = CSR_DATA_W'(radix_ff[0]);
         REG_RADIX_1:     csr_prdata = CSR_DATA_W'(radix_ff[1]);
         REG_RADIX_2:     csr_prdata = CSR_DATA_W'(radix_ff[2]);
         REG_RADIX_3:     csr_prdata = CSR_DATA_W'(radix_ff[3]);
         REG_RADIX_4:     csr_prdata = CSR_DATA_W'(radix_ff[4]);
         REG_RADIX_5:     csr_prdata = CSR_DATA_W'(radix_ff[5]);
         default:         csr_prdata = '0;
      endcase
   end

   assign cnt_eff = (digit_count_ff > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                           : digit_count_ff;

   assign advance      = !chain[NUM_CELLS].valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_comb begin
      chain[0].valid = req_ch.valid;
      chain[0].x     = req_ch.position;
      chain[0].rem   = '0;
      chain[0].acc   = '0;
      chain[0].prod  = PROD_W'(1);
      chain[0].big   = 1'b0;
   end

   for (genvar d = 0; d < MAX_DIGITS; d++) begin : g_digit
      localparam logic [CNT_W-1:0] DIGIT_IDX = CNT_W'(d);
      logic [RADIX_W-1:0] radix_eff;

      // unused digits and a zero radix both act as radix 1
      assign radix_eff = (DIGIT_IDX >= cnt_eff || radix_ff[d] == '0) ? RADIX_W'(1)
                                                                     : radix_ff[d];

      for (genvar b = 0; b < POS_W; b++) begin : g_bit
         mrdr_div_cell u_div (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .radix     (radix_eff),
            .stage_in  (chain[d*CELLS_PER_DIGIT + b]),
            .stage_out (chain[d*CELLS_PER_DIGIT + b + 1])
         );
      end

      mrdr_digit_cell #(.MAX_POINTS(MAX_POINTS)) u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .radix     (radix_eff),
         .stage_in  (chain[d*CELLS_PER_DIGIT + POS_W]),
         .stage_out (chain[(d+1)*CELLS_PER_DIGIT])
      );
   end

   // a nonzero final quotient means position was not below the product
   assign rsp_ch.valid        = chain[NUM_CELLS].valid;
   assign rsp_ch.out_of_range = chain[NUM_CELLS].big || (chain[NUM_CELLS].x != '0);
   assign rsp_ch.source_index = rsp_ch.out_of_range ? '0 : chain[NUM_CELLS].acc;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_of_range |-> rsp_ch.source_index == '0)
      else $error("out-of-range item with nonzero index");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && !req_ch.ready == !rsp_ch.ready)
      else $error("chain moved during stall");
endmodule
`default_nettype wire
